// File: hw/rtl/positional_list_engine_core_defines.svh
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ple_pkg.sv
// Types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE,
    S_SCAN,
    S_READ
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [POS_W-1:0]         found_position;
    logic signed [VAL_W-1:0]  read_value;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

endpackage

// File: hw/rtl/ple_store.sv
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module ple_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/positional_list_engine_core.sv
// Positional list engine: sequencer that walks the entry memory one entry a cycle.
// A request is captured in S_IDLE and checked in S_DECIDE, which ends a rejected one;
// get reads in S_DECIDE and returns in S_READ, insert and remove move N entries in
// S_MOVE, and find scans in S_SCAN until a hit or the end of the list.
// Throughput: one request at a time; a new request is accepted in the done_o cycle.
// Reset clears the length and control state, not the entry memory; done_o cannot stall.
`timescale 1ns / 1ps
`include "positional_list_engine_core_defines.svh"
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam int unsigned EW = (ELEMENT_BITS > VAL_W) ? VAL_W : ELEMENT_BITS;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [EW-1:0]    val_q, val_d;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    src_q, src_d;
  logic [AW-1:0]    dst_q, dst_d;
  logic             pend_q, pend_d;
  logic             up_q, up_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [EW-1:0]    rdata;

  logic [CW-1:0]    pos_w, len_w;
  logic             ins_bad, acc_bad, is_full, cnt_nz, hit, walk_end;
  logic [AW-1:0]    src_step, dst_next;
  logic [CW-1:0]    found_ext;
  logic [VAL_W-1:0] rd_ext;

  ple_store #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pos_w     = CW'(pos_q);
  assign len_w     = CW'(len_q);
  assign ins_bad   = (pos_w == '0) || (pos_w > len_w + CW'(1));
  assign acc_bad   = (pos_w == '0) || (pos_w > len_w);
  assign is_full   = (len_w == CW'(CAPACITY));
  assign cnt_nz    = (cnt_q != '0);
  assign hit       = pend_q && (rdata == val_q);
  assign walk_end  = !cnt_nz && !pend_q;
  assign src_step  = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
  assign dst_next  = up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
  assign found_ext = CW'(dst_q) + CW'(1);
  assign rd_ext    = VAL_W'(rdata);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (op_q)
          OP_INSERT: state_d = (ins_bad || is_full) ? S_IDLE : S_MOVE;
          OP_REMOVE: state_d = acc_bad ? S_IDLE : S_MOVE;
          OP_FIND:   state_d = S_SCAN;
          OP_GET:    state_d = acc_bad ? S_IDLE : S_READ;
          default:   state_d = S_IDLE;
        endcase
      end
      S_MOVE: begin
        if (walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit || walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    logic [CW-1:0] len_ext;
    op_d   = op_q;
    pos_d  = pos_q;
    val_d  = val_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    dst_d  = dst_q;
    up_d   = up_q;
    pend_d = 1'b0;
    done_d = 1'b0;
    rsp_d  = rsp_q;
    we     = 1'b0;
    waddr  = dst_q;
    wdata  = rdata;
    re     = 1'b0;
    raddr  = src_q;
    rsp_d.found_position = rsp_q.found_position;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = req_i.operation;
          pos_d = req_i.position;
          val_d = req_i.value[EW-1:0];
        end
      end
      S_DECIDE: begin
        rsp_d.status         = ST_RANGE;
        rsp_d.found_position = '0;
        rsp_d.read_value     = '0;
        case (op_q)
          OP_INSERT: begin
            if (ins_bad) begin
              done_d = 1'b1;
            end else if (is_full) begin
              done_d       = 1'b1;
              rsp_d.status = ST_FULL;
            end else begin
              up_d  = 1'b1;
              src_d = AW'(len_w - CW'(1));
              cnt_d = LW'(len_w - pos_w + CW'(1));
            end
          end
          OP_REMOVE: begin
            if (acc_bad) begin
              done_d = 1'b1;
            end else begin
              up_d  = 1'b0;
              src_d = AW'(pos_w);
              cnt_d = LW'(len_w - pos_w);
            end
          end
          OP_FIND: begin
            up_d  = 1'b0;
            src_d = '0;
            cnt_d = len_q;
          end
          OP_GET: begin
            if (acc_bad) begin
              done_d = 1'b1;
            end else begin
              re    = 1'b1;
              raddr = AW'(pos_w - CW'(1));
            end
          end
          default: done_d = 1'b1;
        endcase
      end
      S_MOVE: begin
        if (cnt_nz) begin
          re     = 1'b1;
          src_d  = src_step;
          dst_d  = dst_next;
          cnt_d  = cnt_q - LW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          we = 1'b1;
        end
        if (walk_end) begin
          done_d       = 1'b1;
          rsp_d.status = ST_OK;
          if (up_q) begin
            we    = 1'b1;
            waddr = AW'(pos_w - CW'(1));
            wdata = val_q;
            len_d = len_q + LW'(1);
          end else begin
            len_d = len_q - LW'(1);
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          done_d               = 1'b1;
          rsp_d.status         = ST_OK;
          rsp_d.found_position = found_ext[POS_W-1:0];
        end else if (walk_end) begin
          done_d       = 1'b1;
          rsp_d.status = ST_NOT_FOUND;
        end else if (cnt_nz) begin
          re     = 1'b1;
          src_d  = src_step;
          dst_d  = src_q;
          cnt_d  = cnt_q - LW'(1);
          pend_d = 1'b1;
        end
      end
      S_READ: begin
        done_d           = 1'b1;
        rsp_d.status     = ST_OK;
        rsp_d.read_value = rd_ext;
      end
      default: ;
    endcase
    len_ext = CW'(len_d);
    if (done_d) begin
      rsp_d.list_length = len_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      up_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      up_q    <= up_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    pos_q <= pos_d;
    val_q <= val_d;
    src_q <= src_d;
    dst_q <= dst_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `PLE_ASSERT_NEXT(a_req_sets_busy, start_i && !busy_o, busy_o, "busy did not rise after request")
  `PLE_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LW'(CAPACITY), "length above capacity")
  `PLE_ASSERT_NOW(a_err_len_hold, done_o && (rsp_o.status == ST_RANGE || rsp_o.status == ST_FULL), len_q == $past(len_q), "failed request changed length")
  `PLE_ASSERT_NOW(a_err_zero, done_o && rsp_o.status != ST_OK, rsp_o.read_value == '0 && rsp_o.found_position == '0, "error result carries data")
  `PLE_ASSERT_NEXT(a_scan_read, state_q == S_SCAN && cnt_q != '0 && !hit, pend_q, "scan read not issued")

endmodule

// File: tb/sv/positional_list_checker.sv
// Scoreboard for the positional list engine: predicts each response and compares it.
`timescale 1ns / 1ps
module positional_list_checker
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        rsp_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  logic signed [VAL_W-1:0] list_words [CAPACITY];
  int unsigned             list_len = 0;
  rsp_t                    expected_rsps [$];
  int unsigned             error_count = 0;

  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    int unsigned pos;
    int          i;
    res        = '0;
    res.status = ST_OK;
    pos        = r.position;
    case (r.operation)
      OP_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i >= int'(pos); i--) begin
            list_words[i] = list_words[i-1];
          end
          list_words[pos-1] = r.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i < int'(list_len); i++) begin
            list_words[i-1] = list_words[i];
          end
          list_len--;
        end
      end
      OP_FIND: begin
        res.status = ST_NOT_FOUND;
        for (i = 0; i < int'(list_len); i++) begin
          if (list_words[i] == r.value) begin
            res.status         = ST_OK;
            res.found_position = POS_W'(i + 1);
            break;
          end
        end
      end
      default: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[pos-1];
        end
      end
    endcase
    res.list_length = LEN_W'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unrequested response", '0, 64'(rsp_i));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(rsp_i.status));
          if (rsp_i.found_position !== want.found_position)
            report_mismatch("found_position", 64'(want.found_position),
                            64'(rsp_i.found_position));
          if (rsp_i.read_value !== want.read_value)
            report_mismatch("read_value", 64'(want.read_value), 64'(rsp_i.read_value));
          if (rsp_i.list_length !== want.list_length)
            report_mismatch("list_length", 64'(want.list_length), 64'(rsp_i.list_length));
        end
      end
      if (start_i && !busy_i) begin
        expected_rsps.push_back(apply_request(req_i));
      end
    end
    error_count_o <= error_count;
    pending_o     <= expected_rsps.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the positional list engine: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top
  import ple_pkg::*;
();

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned ITEM_COUNT   = 1700;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 8;

  typedef enum int {
    MIX_GROW,
    MIX_FILL,
    MIX_SHRINK,
    MIX_EVEN
  } traffic_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  int unsigned error_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  int unsigned shadow_len = 0;
  int unsigned items_sent = 0;
  bit          no_idle = 1'b0;
  traffic_e    mix;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_engine_core #(
    .CAPACITY    (CAPACITY),
    .ELEMENT_BITS(32)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  positional_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_list_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return VAL_W'(int'($urandom_range(0, 7)) - 4);
    if (r < 75) return $urandom;
    if (r < 85) return 32'h8000_0000;
    if (r < 92) return 32'h7FFF_FFFF;
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
  endfunction

  function automatic int unsigned pick_position(op_e op);
    int unsigned top_pos;
    top_pos = (op == OP_INSERT) ? shadow_len + 1 : shadow_len;
    if (op == OP_FIND) return $urandom_range(0, 127);
    if ($urandom_range(0, 99) < 85 && top_pos >= 1) return $urandom_range(1, top_pos);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top_pos + 1;
      2:       return $urandom_range(0, 127);
      default: return top_pos;
    endcase
  endfunction

  task automatic issue_request(op_e op, int unsigned pos, logic [VAL_W-1:0] val);
    int unsigned r;
    int unsigned gap;
    start <= 1'b1;
    req   <= '{operation: op, position: POS_W'(pos), value: val};
    do @(posedge clk); while (busy);
    items_sent++;
    case (op)
      OP_INSERT: if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY) shadow_len++;
      OP_REMOVE: if (pos >= 1 && pos <= shadow_len) shadow_len--;
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned round_len;
    int unsigned ins_pct;
    int unsigned rem_pct;
    int unsigned r;
    op_e         op;
    rst_n <= 1'b0;
    start <= 1'b0;
    req   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    issue_request(OP_GET, 1, 32'h0);
    issue_request(OP_REMOVE, 1, 32'h0);
    issue_request(OP_FIND, 0, 32'h0);
    issue_request(OP_INSERT, 0, 32'h1);
    issue_request(OP_INSERT, 2, 32'h1);
    // build -1, 0, min, max
    issue_request(OP_INSERT, 1, 32'h8000_0000);
    issue_request(OP_INSERT, 2, 32'h7FFF_FFFF);
    issue_request(OP_INSERT, 1, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 2, 32'h0000_0000);
    issue_request(OP_INSERT, 127, 32'h5);
    for (int p = 0; p <= 5; p++) issue_request(OP_GET, p, 32'h0);
    issue_request(OP_FIND, 127, 32'h7FFF_FFFF);
    issue_request(OP_FIND, 0, 32'hFFFF_FFFF);
    issue_request(OP_FIND, 0, 32'h0000_0005);
    // drop out of range, middle, last, first
    issue_request(OP_REMOVE, 5, 32'h0);
    issue_request(OP_REMOVE, 0, 32'h0);
    issue_request(OP_REMOVE, 2, 32'h0);
    issue_request(OP_REMOVE, 3, 32'h0);
    issue_request(OP_REMOVE, 1, 32'h0);
    issue_request(OP_GET, 1, 32'h0);

    while (items_sent < ITEM_COUNT) begin
      mix       = traffic_e'($urandom_range(0, 3));
      no_idle   = ($urandom_range(0, 4) == 0);
      round_len = $urandom_range(60, 160);
      case (mix)
        MIX_GROW:   begin ins_pct = 50; rem_pct = 15; end
        MIX_FILL:   begin ins_pct = 85; rem_pct = 5;  end
        MIX_SHRINK: begin ins_pct = 10; rem_pct = 55; end
        default:    begin ins_pct = 25; rem_pct = 25; end
      endcase
      repeat (round_len) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + rem_pct) op = OP_REMOVE;
        else if (r < ins_pct + rem_pct + (100 - ins_pct - rem_pct) / 2) op = OP_FIND;
        else op = OP_GET;
        issue_request(op, pick_position(op), pick_value());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
